// ===== rtl/hpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpg_pkg
// shared types and constants for the heap permutation generator
// ----------------------------------------------------------------------------
package hpg_pkg;

  // width of an element value and of a position on the result channel
  localparam int ELEM_W = 3;
  // width of the size register
  localparam int SIZE_W = 4;
  // most elements one run may carry
  localparam int RESULT_LIMIT = 8;
  // size register value after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_WALK,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_PRE,
    ST_EMIT,
    ST_EXH
  } hpg_state_t;

endpackage

// ===== rtl/heap_permutation_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_permutation_generator_unit
// iterative heap's algorithm, one permutation per request beat
// ----------------------------------------------------------------------------
// a fresh start loads the identity, prefetches position 0, then issues n result beats
// an advance walks the level counters, swaps (read a, read b, write a, write b), prefetches, then issues n beats
// an exhausted request walks every level, then issues one result beat
// one request at a time; result beats issue one per cycle while out_stall is low, paced by the order memory port
// reset is synchronous: size returns to 8, progress is dropped, next request starts fresh
// the order memory has no reset; every fresh start rewrites the entries it uses
module heap_permutation_generator_unit #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [hpg_pkg::SIZE_W-1:0] cfg_wr_data,
  // request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       restart,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hpg_pkg::ELEM_W-1:0] element_value,
  output logic [hpg_pkg::ELEM_W-1:0] position,
  output logic                       last_of_run,
  output logic                       exhausted
);

  // only the first min(MAX_ELEMENTS, RESULT_LIMIT) entries can ever be used
  localparam int DEPTH = (MAX_ELEMENTS < hpg_pkg::RESULT_LIMIT) ?
                         MAX_ELEMENTS : hpg_pkg::RESULT_LIMIT;
  localparam int AW  = $clog2(DEPTH);
  localparam int LPW = $clog2(DEPTH + 1);

  hpg_pkg::hpg_state_t state, state_next;

  logic [hpg_pkg::SIZE_W-1:0] size_in_use;
  logic                       started;
  logic [LPW-1:0]             active_n;
  logic [LPW-1:0]             lp;          // level pointer
  logic [AW-1:0]              cnt [DEPTH]; // level counters
  logic [AW-1:0]              idx;         // fill / emit index
  logic [AW-1:0]              partner;
  logic [hpg_pkg::ELEM_W-1:0] held;

  // order store, one write and one registered read port
  logic [hpg_pkg::ELEM_W-1:0] order_mem [DEPTH];
  logic [hpg_pkg::ELEM_W-1:0] rd_data;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [hpg_pkg::ELEM_W-1:0] mem_wdata;
  logic [AW-1:0]              rd_addr;

  logic [LPW-1:0] eff_size;
  logic [AW-1:0]  lp_a;
  logic [AW-1:0]  cnt_lp;
  logic           cnt_below;
  logic           lp_done;
  logic           idx_last;
  logic           in_accept;
  logic           out_free;
  logic           out_load;

  // effective size: saturate the register into 1..DEPTH
  always_comb begin
    if (size_in_use == '0) begin
      eff_size = LPW'(1);
    end else if (size_in_use > hpg_pkg::SIZE_W'(DEPTH)) begin
      eff_size = LPW'(DEPTH);
    end else begin
      eff_size = LPW'(size_in_use);
    end
  end

  assign lp_a      = lp[AW-1:0];
  assign cnt_lp    = cnt[lp_a];
  assign cnt_below = LPW'(cnt_lp) < lp;
  assign lp_done   = lp >= active_n;
  assign idx_last  = LPW'(idx) == (active_n - LPW'(1));
  assign in_stall  = state != hpg_pkg::ST_IDLE;
  assign in_accept = in_valid && !in_stall;
  // the result register can take a new beat when empty or being drained
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and memory port control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = hpg_pkg::ELEM_W'(idx);
    rd_addr    = idx;
    out_load   = 1'b0;
    unique case (state)
      hpg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (restart || !started) ? hpg_pkg::ST_FILL : hpg_pkg::ST_WALK;
        end
      end
      hpg_pkg::ST_FILL: begin
        // identity load, one entry a cycle
        mem_we = 1'b1;
        if (idx_last) begin
          state_next = hpg_pkg::ST_PRE;
        end
      end
      hpg_pkg::ST_WALK: begin
        // one counter level per cycle until a level can swap or all levels are spent
        if (lp_done) begin
          state_next = hpg_pkg::ST_EXH;
        end else if (cnt_below) begin
          state_next = hpg_pkg::ST_RD_A;
        end
      end
      hpg_pkg::ST_RD_A: begin
        rd_addr    = lp_a;
        state_next = hpg_pkg::ST_RD_B;
      end
      hpg_pkg::ST_RD_B: begin
        rd_addr    = partner;
        state_next = hpg_pkg::ST_WR_A;
      end
      hpg_pkg::ST_WR_A: begin
        mem_we     = 1'b1;
        mem_waddr  = lp_a;
        mem_wdata  = rd_data;
        state_next = hpg_pkg::ST_WR_B;
      end
      hpg_pkg::ST_WR_B: begin
        mem_we     = 1'b1;
        mem_waddr  = partner;
        mem_wdata  = held;
        state_next = hpg_pkg::ST_PRE;
      end
      hpg_pkg::ST_PRE: begin
        // fetch position 0 ahead of the first beat
        rd_addr    = '0;
        state_next = hpg_pkg::ST_EMIT;
      end
      hpg_pkg::ST_EMIT: begin
        // read address looks one entry ahead whenever a beat is loaded
        if (out_free) begin
          out_load = 1'b1;
          rd_addr  = idx + AW'(1);
          if (idx_last) begin
            state_next = hpg_pkg::ST_IDLE;
          end
        end
      end
      hpg_pkg::ST_EXH: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = hpg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      order_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= order_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= hpg_pkg::SIZE_RESET;
      started     <= 1'b0;
      active_n    <= LPW'(DEPTH);
      lp          <= '0;
      idx         <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      unique case (state)
        hpg_pkg::ST_IDLE: begin
          if (in_accept && (restart || !started)) begin
            // fresh start from identity
            started  <= 1'b1;
            active_n <= eff_size;
            lp       <= '0;
            idx      <= '0;
            for (int i = 0; i < DEPTH; i++) begin
              cnt[i] <= '0;
            end
          end
        end
        hpg_pkg::ST_FILL: begin
          idx <= idx_last ? '0 : idx + AW'(1);
        end
        hpg_pkg::ST_WALK: begin
          if (!lp_done && !cnt_below) begin
            cnt[lp_a] <= '0;
            lp        <= lp + LPW'(1);
          end
        end
        hpg_pkg::ST_WR_B: begin
          cnt[lp_a] <= cnt_lp + AW'(1);
          lp        <= '0;
          idx       <= '0;
        end
        hpg_pkg::ST_EMIT: begin
          if (out_load) begin
            idx <= idx_last ? '0 : idx + AW'(1);
          end
        end
        default: begin
        end
      endcase
      // any size write forces a fresh start on the next request
      if (cfg_wr_en) begin
        size_in_use <= cfg_wr_data;
        started     <= 1'b0;
      end
    end
  end

  // swap operands
  always_ff @(posedge clk) begin
    if (state == hpg_pkg::ST_WALK) begin
      // even level swaps with position 0, odd level with its counter
      partner <= lp[0] ? cnt_lp : '0;
    end
    if (state == hpg_pkg::ST_RD_B) begin
      held <= rd_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == hpg_pkg::ST_EXH) begin
        element_value <= '0;
        position      <= '0;
        last_of_run   <= 1'b1;
        exhausted     <= 1'b1;
      end else begin
        element_value <= rd_data;
        position      <= hpg_pkg::ELEM_W'(idx);
        last_of_run   <= idx_last;
        exhausted     <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // the exhausted beat carries zero fields and closes its run
  a_exh_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> last_of_run && element_value == '0 && position == '0)
    else $error("exhausted beat with bad fields");

  // a run closes exactly at position n-1
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !exhausted && last_of_run |->
      LPW'(position) == (active_n - LPW'(1)))
    else $error("run closed at wrong position");

  // level counters never pass their level while walking
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == hpg_pkg::ST_WALK && !lp_done |-> LPW'(cnt_lp) <= lp)
    else $error("level counter above its level");

  // a swap is only started from the walk, with a partner other than its own level
  a_swap_entry: assert property (@(posedge clk) disable iff (rst)
    state == hpg_pkg::ST_RD_A |-> $past(state) == hpg_pkg::ST_WALK && partner != lp_a)
    else $error("swap started without a valid partner");

  // walking the levels only happens after a fresh start
  a_started: assert property (@(posedge clk) disable iff (rst)
    state == hpg_pkg::ST_WALK |-> started)
    else $error("advance without a started sequence");
`endif

endmodule

// ===== dv/tb_heap_permutation_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heap_permutation_generator_unit
// request-level check of the heap permutation generator: a directed table covers
// reset, restart, size saturation, single element and exhaustion, then random
// phases at many sizes run small sizes to exhaustion under random idling, with
// one long receiver hold; each result beat is checked against its row or a local predictor
// ----------------------------------------------------------------------------
module tb_heap_permutation_generator_unit;

  localparam int MAX_EL        = 8;
  localparam int IDLE_LIMIT    = 4000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;     // quiet cycles before a size write
  localparam int DRAIN_CYCLES  = 40;    // walk + swap + prefetch + a full run
  localparam int RANDOM_ITEMS  = 290;
  localparam int REPORT_MAX    = 10;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [hpg_pkg::ELEM_W-1:0] elem;
    logic [hpg_pkg::ELEM_W-1:0] pos;
    logic                       last;
    logic                       exh;
  } perm_beat_t;

  // how a directed row gets its expected beats
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_IDENTITY,
    CHK_EXHAUSTED
  } row_check_t;

  typedef struct packed {
    logic                       do_cfg;
    logic [hpg_pkg::SIZE_W-1:0] cfg_val;
    logic                       rs;
    row_check_t                 check;
    logic [3:0]                 id_len;
  } dir_row_t;

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       cfg_wr_en   = 1'b0;
  logic [hpg_pkg::SIZE_W-1:0] cfg_wr_data = '0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  logic                       restart     = 1'b0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  logic [hpg_pkg::ELEM_W-1:0] element_value;
  logic [hpg_pkg::ELEM_W-1:0] position;
  logic                       last_of_run;
  logic                       exhausted;

  // random idling control: calm is shared by both sides, hold_req asks the receiver to hold
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  // predictor state
  logic [hpg_pkg::SIZE_W-1:0] size_reg = hpg_pkg::SIZE_RESET;
  logic [hpg_pkg::ELEM_W-1:0] perm_order  [MAX_EL];
  logic [hpg_pkg::ELEM_W-1:0] level_count [MAX_EL];
  int                         level_ptr;
  int                         run_len;
  bit                         perm_started = 1'b0;

  perm_beat_t beats_due[$];
  int         mismatches  = 0;
  int         idle_cycles = 0;

  // directed rows: typed expectations only where they are obvious
  dir_row_t dir_rows [24] = '{
    '{1'b0, 4'd0,  1'b0, CHK_IDENTITY,  4'd8},  // first request after reset
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b1, CHK_IDENTITY,  4'd8},  // restart mid-sequence
    '{1'b1, 4'd1,  1'b0, CHK_IDENTITY,  4'd1},  // single element
    '{1'b0, 4'd0,  1'b0, CHK_EXHAUSTED, 4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_EXHAUSTED, 4'd0},
    '{1'b0, 4'd0,  1'b1, CHK_IDENTITY,  4'd1},  // restart after exhaustion
    '{1'b1, 4'd0,  1'b0, CHK_IDENTITY,  4'd1},  // zero size saturates to one
    '{1'b0, 4'd0,  1'b0, CHK_EXHAUSTED, 4'd0},
    '{1'b1, 4'd15, 1'b0, CHK_IDENTITY,  4'd8},  // oversize saturates to max
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b1, 4'd2,  1'b0, CHK_IDENTITY,  4'd2},
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_EXHAUSTED, 4'd0},
    '{1'b1, 4'd2,  1'b0, CHK_IDENTITY,  4'd2},  // same value rewritten still restarts
    '{1'b1, 4'd3,  1'b1, CHK_IDENTITY,  4'd3},
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_MODEL,     4'd0},
    '{1'b0, 4'd0,  1'b0, CHK_EXHAUSTED, 4'd0},  // all six orderings of three done
    '{1'b0, 4'd0,  1'b1, CHK_IDENTITY,  4'd3},
    '{1'b1, 4'd8,  1'b0, CHK_IDENTITY,  4'd8}
  };

  heap_permutation_generator_unit #(
    .MAX_ELEMENTS(MAX_EL)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .element_value(element_value),
    .position     (position),
    .last_of_run  (last_of_run),
    .exhausted    (exhausted)
  );

  always #1 clk = ~clk;

  // size register value clamped to the range the block permutes
  function automatic int clamp_size(logic [hpg_pkg::SIZE_W-1:0] v);
    int n;
    n = v;
    if (n < 1) n = 1;
    if (n > MAX_EL) n = MAX_EL;
    if (n > hpg_pkg::RESULT_LIMIT) n = hpg_pkg::RESULT_LIMIT;
    return n;
  endfunction

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // next heap's-algorithm ordering (or identity on a fresh start) as result beats
  function automatic void predict_perm_run(input logic rs, ref perm_beat_t run[$]);
    int                         lv;
    bit                         fresh;
    logic [hpg_pkg::ELEM_W-1:0] partner;
    logic [hpg_pkg::ELEM_W-1:0] tmp;
    run.delete();
    fresh = 1'b0;
    if (rs || !perm_started) begin
      for (int k = 0; k < MAX_EL; k++) begin
        perm_order[k]  = k[hpg_pkg::ELEM_W-1:0];
        level_count[k] = '0;
      end
      level_ptr    = 0;
      run_len      = clamp_size(size_reg);
      perm_started = 1'b1;
      fresh        = 1'b1;
    end else begin
      // climb levels until one still has a swap left
      while (!fresh && level_ptr < run_len) begin
        lv = level_ptr;
        if (level_count[lv] < lv) begin
          // even level swaps with the head, odd level with its counter
          partner = lv[0] ? level_count[lv] : '0;
          tmp = perm_order[partner];
          perm_order[partner] = perm_order[lv];
          perm_order[lv] = tmp;
          level_count[lv] = level_count[lv] + 1'b1;
          level_ptr = 0;
          fresh = 1'b1;
        end else begin
          level_count[lv] = '0;
          level_ptr = lv + 1;
        end
      end
    end
    if (fresh) begin
      for (int k = 0; k < run_len; k++)
        run.push_back('{perm_order[k], k[hpg_pkg::ELEM_W-1:0], (k == run_len - 1), 1'b0});
    end else begin
      run.push_back('{'0, '0, 1'b1, 1'b1});
    end
  endfunction

  function automatic void note_mismatch(string what, perm_beat_t want, perm_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: exp elem/pos/last/exh %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
               $realtime, what, want.elem, want.pos, want.last, want.exh,
               got.elem, got.pos, got.last, got.exh);
  endfunction

  // offer one request beat, then queue the beats it should produce
  task automatic offer_request(input logic rs, input row_check_t check,
                               input logic [3:0] id_len);
    int         gap;
    perm_beat_t run[$];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(0, 1));  // noise on an idle channel
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    predict_perm_run(rs, run);
    case (check)
      CHK_IDENTITY: begin
        for (int k = 0; k < id_len; k++)
          beats_due.push_back('{k[hpg_pkg::ELEM_W-1:0], k[hpg_pkg::ELEM_W-1:0],
                                (k == id_len - 1), 1'b0});
      end
      CHK_EXHAUSTED: begin
        beats_due.push_back('{'0, '0, 1'b1, 1'b1});
      end
      default: begin
        foreach (run[i]) beats_due.push_back(run[i]);
      end
    endcase
  endtask

  // size writes only once the block has drained
  task automatic write_size(input logic [hpg_pkg::SIZE_W-1:0] v);
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    size_reg     = v;
    perm_started = 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold when asked
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // compare every accepted result beat against the oldest expectation
  always @(posedge clk) begin : check_beats
    perm_beat_t got;
    perm_beat_t want;
    if (out_valid && !out_stall) begin
      got = '{element_value, position, last_of_run, exhausted};
      if (beats_due.size() == 0) begin
        note_mismatch("unexpected beat", '0, got);
      end else begin
        want = beats_due.pop_front();
        if (got !== want) note_mismatch("beat mismatch", want, got);
      end
    end
  end

  // watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("heap_permutation_generator_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int         items_sent;
    int         n;
    int         r;
    int         perms;
    int         phase_items;
    logic [3:0] sz;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) write_size(dir_rows[i].cfg_val);
      offer_request(dir_rows[i].rs, dir_rows[i].check, dir_rows[i].id_len);
    end

    // back-pressure: the sender keeps offering while the receiver holds off
    write_size(4'd8);
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (12) offer_request(($urandom_range(0, 9) == 0), CHK_MODEL, 4'd0);
    calm = 1'b0;

    // random phases: small sizes run through to exhaustion, large ones sampled
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 10)      sz = 4'($urandom_range(1, 4));
      else if (r < 13) sz = 4'd5;
      else if (r < 15) sz = 4'($urandom_range(6, 8));
      else if (r < 17) sz = 4'd0;
      else             sz = 4'($urandom_range(9, 15));
      write_size(sz);
      n = clamp_size(sz);
      perms = (n == 1) ? 1 : (n == 2) ? 2 : (n == 3) ? 6 : 24;
      phase_items = (n <= 4) ? perms + $urandom_range(1, 4) : $urandom_range(8, 24);
      calm = ($urandom_range(0, 3) == 0);
      repeat (phase_items) begin
        // mostly plain advances, now and then a restart mid-sequence
        offer_request(($urandom_range(0, 24) == 0), CHK_MODEL, 4'd0);
        items_sent++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then give stray beats a chance to show up
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += beats_due.size();
    if (mismatches == 0) begin
      $display("heap_permutation_generator_unit regression: pass");
    end else begin
      $display("heap_permutation_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
